>>> sv/pvas_pkg.sv
// Package for the polar vector add/sub core: formats, constants, CORDIC angle table.
// No dependencies.
package pvas_pkg;

  localparam int IterDefault = 16;
  localparam int IterMax     = 24;
  localparam int HalfTurn    = 46080;
  localparam int QuarterTurn = 23040;
  localparam int FullTurn    = 92160;
  localparam logic [23:0] GainQ24 = 24'd10188014;

  // coordinate width: |r| <= 2^23, Q.12 -> 2^35, CORDIC growth <2, sums x2 -> 38 bits
  localparam int CW = 40;
  // angle accumulator in 2^-20 degree, |z| < 2^29 incl. pre-rotation
  localparam int ZW = 32;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [ZW-1:0] zang_t;

  function automatic zang_t atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 32'sd47185920;
      5'd1:  atan_lut = 32'sd27855475;
      5'd2:  atan_lut = 32'sd14718068;
      5'd3:  atan_lut = 32'sd7471121;
      5'd4:  atan_lut = 32'sd3750058;
      5'd5:  atan_lut = 32'sd1876857;
      5'd6:  atan_lut = 32'sd938658;
      5'd7:  atan_lut = 32'sd469357;
      5'd8:  atan_lut = 32'sd234682;
      5'd9:  atan_lut = 32'sd117342;
      5'd10: atan_lut = 32'sd58671;
      5'd11: atan_lut = 32'sd29335;
      5'd12: atan_lut = 32'sd14668;
      5'd13: atan_lut = 32'sd7334;
      5'd14: atan_lut = 32'sd3667;
      5'd15: atan_lut = 32'sd1833;
      5'd16: atan_lut = 32'sd917;
      5'd17: atan_lut = 32'sd458;
      5'd18: atan_lut = 32'sd229;
      5'd19: atan_lut = 32'sd115;
      5'd20: atan_lut = 32'sd57;
      5'd21: atan_lut = 32'sd29;
      5'd22: atan_lut = 32'sd14;
      5'd23: atan_lut = 32'sd7;
      default: atan_lut = '0;
    endcase
  endfunction

endpackage

>>> sv/pvas_to_cart.sv
// Polar to Cartesian conversion: angle reduction plus a pipelined rotation CORDIC.
// Depends on pvas_pkg. Registers stage A, stage B, the CORDIC stages and the output; advances on en.
module pvas_to_cart #(
  parameter int ITERATIONS = pvas_pkg::IterDefault
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [23:0]   radius,
  input  logic signed [17:0]   angle,
  output pvas_pkg::coord_t     x,
  output pvas_pkg::coord_t     y
);

  localparam int N = ITERATIONS;

  // exact-axis codes carried beside the CORDIC chain
  localparam logic [1:0] AxisNone = 2'd0;
  localparam logic [1:0] AxisZero = 2'd1;
  localparam logic [1:0] AxisPos  = 2'd2;
  localparam logic [1:0] AxisNeg  = 2'd3;

  // stage A: fix sign, take modulo 360
  logic [23:0]        a_r;
  logic signed [18:0] a_ang;
  logic signed [18:0] ang_in;
  logic signed [18:0] ang_m;

  always_comb begin
    ang_in = radius[23] ? (19'(angle) + 19'(pvas_pkg::HalfTurn)) : 19'(angle);
    // |ang_in| < 2*FullTurn: reduce to [0, FullTurn)
    ang_m = ang_in;
    if (ang_m < 0) ang_m = ang_m + 19'(pvas_pkg::FullTurn);
    if (ang_m < 0) ang_m = ang_m + 19'(pvas_pkg::FullTurn);
    if (ang_m >= 19'(pvas_pkg::FullTurn)) ang_m = ang_m - 19'(pvas_pkg::FullTurn);
    if (ang_m >= 19'(pvas_pkg::FullTurn)) ang_m = ang_m - 19'(pvas_pkg::FullTurn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= radius[23] ? 24'(-radius) : radius;
      a_ang <= ang_m;
    end
  end

  // CORDIC stages
  pvas_pkg::coord_t cx [N+1];
  pvas_pkg::coord_t cy [N+1];
  pvas_pkg::zang_t  cz [N+1];
  logic             cneg [N+1];
  logic [1:0]       cax  [N+1];
  logic [23:0]      cr   [N+1];

  // stage B: fold into [-90,90], gain multiply, load the first CORDIC stage
  logic signed [18:0] fa;
  logic               fneg;
  logic [1:0]         fax;

  always_comb begin
    fa = a_ang;
    fneg = 1'b0;
    if (fa > 19'(pvas_pkg::HalfTurn)) fa = fa - 19'(pvas_pkg::FullTurn);
    if (fa > 19'(pvas_pkg::QuarterTurn)) begin
      fa = fa - 19'(pvas_pkg::HalfTurn);
      fneg = 1'b1;
    end else if (fa < -19'(pvas_pkg::QuarterTurn)) begin
      fa = fa + 19'(pvas_pkg::HalfTurn);
      fneg = 1'b1;
    end
    if (fa == 0) fax = AxisZero;
    else if (fa == 19'(pvas_pkg::QuarterTurn)) fax = AxisPos;
    else if (fa == -19'(pvas_pkg::QuarterTurn)) fax = AxisNeg;
    else fax = AxisNone;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= pvas_pkg::CW'((48'(a_r) * 48'(pvas_pkg::GainQ24) + 48'd2048) >> 12);
      cy[0]   <= '0;
      cz[0]   <= pvas_pkg::ZW'(fa) <<< 12;
      cneg[0] <= fneg;
      cax[0]  <= fax;
      cr[0]   <= a_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    pvas_pkg::coord_t dx, dy;
    assign dx = cx[i] >>> i;
    assign dy = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][pvas_pkg::ZW-1]) begin
          cx[i+1] <= cx[i] - dy;
          cy[i+1] <= cy[i] + dx;
          cz[i+1] <= cz[i] - pvas_pkg::atan_lut(5'(i));
        end else begin
          cx[i+1] <= cx[i] + dy;
          cy[i+1] <= cy[i] - dx;
          cz[i+1] <= cz[i] + pvas_pkg::atan_lut(5'(i));
        end
        cneg[i+1] <= cneg[i];
        cax[i+1]  <= cax[i];
        cr[i+1]   <= cr[i];
      end
    end
  end

  // output stage: exact axes, unfold
  pvas_pkg::coord_t ox, oy, rq;
  always_comb begin
    rq = pvas_pkg::CW'(cr[N]) <<< 12;
    case (cax[N])
      AxisZero: begin ox = rq; oy = '0; end
      AxisPos:  begin ox = '0; oy = rq; end
      AxisNeg:  begin ox = '0; oy = -rq; end
      default: begin ox = cx[N]; oy = cy[N]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= cneg[N] ? -ox : ox;
      y <= cneg[N] ? -oy : oy;
    end
  end

endmodule

>>> sv/pvas_to_polar.sv
// Cartesian to polar: pipelined vectoring CORDIC, gain multiply, angle wrap.
// Depends on pvas_pkg. Registers the entry stage, the CORDIC stages, the gain stage and the output; advances on en.
module pvas_to_polar #(
  parameter int ITERATIONS = pvas_pkg::IterDefault
) (
  input  logic                 clk,
  input  logic                 en,
  input  pvas_pkg::coord_t     x,
  input  pvas_pkg::coord_t     y,
  output logic [23:0]          mag,
  output logic signed [16:0]   ang
);

  localparam int N = ITERATIONS;
  localparam int MW = pvas_pkg::CW + 24;

  typedef struct packed {
    logic xz;
    logic yz;
    logic xneg;
    logic ypos;
  } flags_t;

  pvas_pkg::coord_t vx [N+1];
  pvas_pkg::coord_t vy [N+1];
  pvas_pkg::zang_t  vz [N+1];
  flags_t           vf [N+1];

  // entry stage: flags and left half plane flip
  always_ff @(posedge clk) begin
    if (en) begin
      vf[0].xz   <= (x == 0);
      vf[0].yz   <= (y == 0);
      vf[0].xneg <= x[pvas_pkg::CW-1];
      vf[0].ypos <= !y[pvas_pkg::CW-1] && (y != 0);
      if (x[pvas_pkg::CW-1]) begin
        vx[0] <= -x;
        vy[0] <= -y;
        vz[0] <= y[pvas_pkg::CW-1] ? -pvas_pkg::ZW'(pvas_pkg::HalfTurn * 4096)
                                   : pvas_pkg::ZW'(pvas_pkg::HalfTurn * 4096);
      end else begin
        vx[0] <= x;
        vy[0] <= y;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    pvas_pkg::coord_t dx, dy;
    assign dx = vy[i] >>> i;
    assign dy = vx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy[i][pvas_pkg::CW-1]) begin
          vx[i+1] <= vx[i] + dx;
          vy[i+1] <= vy[i] - dy;
          vz[i+1] <= vz[i] + pvas_pkg::atan_lut(5'(i));
        end else begin
          vx[i+1] <= vx[i] - dx;
          vy[i+1] <= vy[i] + dy;
          vz[i+1] <= vz[i] - pvas_pkg::atan_lut(5'(i));
        end
        vf[i+1] <= vf[i];
      end
    end
  end

  // gain multiply and angle rounding
  logic [MW-1:0]      p_prod;
  logic signed [19:0] p_ang;
  flags_t             p_f;
  pvas_pkg::zang_t    zr;

  assign zr = (vz[N] + pvas_pkg::ZW'(2048)) >>> 12;

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod <= MW'(vx[N]) * MW'(pvas_pkg::GainQ24);
      p_ang  <= 20'(zr);
      p_f    <= vf[N];
    end
  end

  logic [MW-1:0]      mq;
  logic signed [19:0] aw;
  logic signed [16:0] af;

  always_comb begin
    mq = (p_prod + (MW'(1) << 35)) >> 36;
    aw = p_ang;
    if (aw <= -20'(pvas_pkg::HalfTurn)) aw = aw + 20'(pvas_pkg::FullTurn);
    if (aw > 20'(pvas_pkg::HalfTurn)) aw = aw - 20'(pvas_pkg::FullTurn);
    if (p_f.xz)
      af = p_f.yz ? '0 : (p_f.ypos ? 17'(pvas_pkg::QuarterTurn)
                                   : -17'(pvas_pkg::QuarterTurn));
    else if (p_f.yz)
      af = p_f.xneg ? 17'(pvas_pkg::HalfTurn) : '0;
    else
      af = 17'(aw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= (mq > MW'(24'hFFFFFF)) ? 24'hFFFFFF : mq[23:0];
      ang <= af;
    end
  end

endmodule

>>> sv/polar_vector_add_sub_core.sv
// Polar vector add/sub core: two polar CORDIC front ends, add/sub, vectoring back end.
// Depends on pvas_pkg, pvas_to_cart, pvas_to_polar.
//
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | tdata: first_radius[23:0] first_angle[41:24] second_radius[65:42]
//          |     |        second_angle[83:66], pad to 88; tuser: func
//  m_axis  | out | tdata: sum_radius[23:0] sum_angle[40:24], pad to 48
//
// One beat per cycle while the output is not stalled. Depth is set by the two
// CORDIC chains. Synchronous reset clears only the valid bits. The whole pipeline
// advances when the output slot is free or taken; a stall freezes every stage.
module polar_vector_add_sub_core #(
  parameter int ITERATIONS = pvas_pkg::IterDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // first_radius, first_angle, second_radius, second_angle
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // sum_radius, sum_angle
  output logic        m_axis_tuser    // unused, zero
);

  localparam int LatCart = ITERATIONS + 3;
  localparam int Lat     = 2 * ITERATIONS + 7;

  logic en;
  logic [Lat-1:0] vld;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];
  assign m_axis_tuser  = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end

  // func delay line
  logic [LatCart-1:0] fdl;
  always_ff @(posedge clk) begin
    if (en) fdl <= {fdl[LatCart-2:0], s_axis_tuser};
  end

  pvas_pkg::coord_t x1, y1, x2, y2, sx, sy;

  pvas_to_cart #(.ITERATIONS(ITERATIONS)) u_cart1 (
    .clk(clk), .en(en),
    .radius(s_axis_tdata[23:0]), .angle(s_axis_tdata[41:24]),
    .x(x1), .y(y1)
  );
  pvas_to_cart #(.ITERATIONS(ITERATIONS)) u_cart2 (
    .clk(clk), .en(en),
    .radius(s_axis_tdata[65:42]), .angle(s_axis_tdata[83:66]),
    .x(x2), .y(y2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= fdl[LatCart-1] ? x1 - x2 : x1 + x2;
      sy <= fdl[LatCart-1] ? y1 - y2 : y1 + y2;
    end
  end

  logic [23:0]        mag;
  logic signed [16:0] ang;

  pvas_to_polar #(.ITERATIONS(ITERATIONS)) u_polar (
    .clk(clk), .en(en), .x(sx), .y(sy), .mag(mag), .ang(ang)
  );

  assign m_axis_tdata = {7'd0, ang, mag};

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline stalled");
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[40:24]) > -17'sd46080)
                   && ($signed(m_axis_tdata[40:24]) <= 17'sd46080))
    else $error("angle out of range");

endmodule

>>> tb/polar_vector_add_sub_core_checker.sv
// Checker for polar_vector_add_sub_core: watches both stream channels, predicts each
// result from the input beat and compares it field by field. Depends on pvas_pkg.
module polar_vector_add_sub_core_checker #(
  parameter int ITERATIONS = pvas_pkg::IterDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0]        radius;
    logic signed [16:0] angle;
  } polar_sum_t;

  polar_sum_t expected_sums[$];

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(input int i);
    longint t[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                      469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                      917, 458, 229, 115, 57, 29, 14, 7};
    return t[i];
  endfunction

  // polar to Q.12 cartesian, folding the angle into [-90,90]
  function automatic void polar_to_xy(input logic signed [23:0] rad,
                                      input logic signed [17:0] ang,
                                      output longint xo, output longint yo);
    longint r, a, x, y, z, dx, dy;
    bit flip;
    r = rad;
    a = ang;
    flip = 0;
    if (r < 0) begin
      r = -r;
      a += pvas_pkg::HalfTurn;
    end
    a = a % pvas_pkg::FullTurn;
    if (a < 0) a += pvas_pkg::FullTurn;
    if (a > pvas_pkg::HalfTurn) a -= pvas_pkg::FullTurn;
    if (a > pvas_pkg::QuarterTurn) begin
      a -= pvas_pkg::HalfTurn;
      flip = 1;
    end else if (a < -pvas_pkg::QuarterTurn) begin
      a += pvas_pkg::HalfTurn;
      flip = 1;
    end
    if (a == 0) begin
      x = r * 4096;
      y = 0;
    end else if (a == pvas_pkg::QuarterTurn) begin
      x = 0;
      y = r * 4096;
    end else if (a == -pvas_pkg::QuarterTurn) begin
      x = 0;
      y = -r * 4096;
    end else begin
      x = (r * longint'(pvas_pkg::GainQ24) + 2048) >>> 12;
      y = 0;
      z = a * 4096;
      for (int i = 0; i < ITERATIONS && i < pvas_pkg::IterMax; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_entry(i);
        end else begin
          x += dx;
          y -= dy;
          z += atan_entry(i);
        end
      end
    end
    xo = flip ? -x : x;
    yo = flip ? -y : y;
  endfunction

  function automatic polar_sum_t predict_sum(input logic [87:0] d, input logic subtract);
    longint x1, y1, x2, y2, sx, sy, z, base, a, dx, dy, mag;
    polar_sum_t res;
    bit xz, yz, xneg, ypos;
    polar_to_xy(d[23:0], d[41:24], x1, y1);
    polar_to_xy(d[65:42], d[83:66], x2, y2);
    sx = subtract ? x1 - x2 : x1 + x2;
    sy = subtract ? y1 - y2 : y1 + y2;
    xz = sx == 0;
    yz = sy == 0;
    xneg = sx < 0;
    ypos = sy > 0;
    z = 0;
    base = 0;
    if (sx < 0) begin
      base = (sy >= 0) ? longint'(pvas_pkg::HalfTurn) * 4096
                       : -longint'(pvas_pkg::HalfTurn) * 4096;
      sx = -sx;
      sy = -sy;
    end
    for (int i = 0; i < ITERATIONS && i < pvas_pkg::IterMax; i++) begin
      dx = floor_shr(sy, i);
      dy = floor_shr(sx, i);
      if (sy >= 0) begin
        sx += dx;
        sy -= dy;
        z += atan_entry(i);
      end else begin
        sx -= dx;
        sy += dy;
        z -= atan_entry(i);
      end
    end
    mag = (sx * longint'(pvas_pkg::GainQ24) + (longint'(1) << 35)) >>> 36;
    if (mag > 24'hFFFFFF) mag = 24'hFFFFFF;
    if (xz) a = yz ? 0 : (ypos ? pvas_pkg::QuarterTurn : -pvas_pkg::QuarterTurn);
    else if (yz) a = xneg ? pvas_pkg::HalfTurn : 0;
    else begin
      a = floor_shr(base + z + 2048, 12);
      while (a <= -pvas_pkg::HalfTurn) a += pvas_pkg::FullTurn;
      while (a > pvas_pkg::HalfTurn) a -= pvas_pkg::FullTurn;
    end
    res.radius = mag[23:0];
    res.angle = a[16:0];
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    polar_sum_t want, got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_sums.push_back(predict_sum(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        got.radius = m_axis_tdata[23:0];
        got.angle = m_axis_tdata[40:24];
        if (expected_sums.size() == 0) begin
          fail_count++;
          $display("%t: unexpected beat radius=%0d angle=%0d", $realtime,
                   got.radius, got.angle);
        end else begin
          want = expected_sums.pop_front();
          if (got.radius !== want.radius) begin
            fail_count++;
            $display("%t: sum_radius expected %0d actual %0d", $realtime,
                     want.radius, got.radius);
          end
          if (got.angle !== want.angle) begin
            fail_count++;
            $display("%t: sum_angle expected %0d actual %0d", $realtime,
                     want.angle, got.angle);
          end
        end
      end
    end
    pending = expected_sums.size();
  end
endmodule

>>> tb/polar_vector_add_sub_core_test.sv
// Top of the polar_vector_add_sub_core testbench: clock, reset, stimulus, stalls, verdict.
// Depends on pvas_pkg, polar_vector_add_sub_core and polar_vector_add_sub_core_checker.
module polar_vector_add_sub_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 2 * pvas_pkg::IterDefault + 7;
  localparam int IdleLimit = 5000;
  localparam int RandomItems = 1430;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count;
  int          pending;
  bit          long_hold;
  int          idle_cycles;

  polar_vector_add_sub_core dut (.*);

  polar_vector_add_sub_core_checker checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // offer one beat and hold it until it is taken
  task automatic send_pair(input logic subtract, input logic signed [23:0] r1,
                           input logic signed [17:0] a1, input logic signed [23:0] r2,
                           input logic signed [17:0] a2);
    s_axis_tvalid <= 1;
    s_axis_tuser <= subtract;
    s_axis_tdata <= {4'b0, a2, r2, a1, r1};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 255)) - 24'sd128;
      1: return 24'($urandom);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom_range(0, 65535)) - 24'sd32768;
    endcase
  endfunction

  function automatic logic signed [17:0] rand_angle();
    int a;
    case ($urandom_range(0, 3))
      0: a = 23040 * ($urandom_range(0, 8) - 4);
      1: a = $urandom_range(0, 184318) - 92159;
      2: a = $urandom_range(0, 1) ? 92159 : -92159;
      default: a = $urandom_range(0, 2048) - 1024;
    endcase
    return a[17:0];
  endfunction

  // receiver: random stalls, some stretches always ready, one long hold-off
  initial begin
    int mode;
    int cyc;
    m_axis_tready = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (long_hold) m_axis_tready <= 0;
      else begin
        mode = (cyc / 1000) % 3;
        m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (++idle_cycles >= IdleLimit) begin
        $display("polar_vector_add_sub_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int gap, burst;
    rst = 1;
    long_hold = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, axes, cancellation, zero vector, left half plane
    send_pair(0, 0, 0, 0, 0);
    send_pair(1, 24'sh7FFFFF, 0, 24'sh7FFFFF, 0);
    send_pair(0, 24'sh7FFFFF, 0, 24'sh7FFFFF, 0);
    send_pair(0, 24'sh800000, 0, 24'sh800000, 0);
    send_pair(1, 24'sh800000, 18'sd92159, 24'sh7FFFFF, -18'sd92159);
    send_pair(0, 256, 23040, 0, 0);
    send_pair(0, 256, -23040, 0, 0);
    send_pair(0, -256, 0, 0, 0);
    send_pair(0, 256, 46080, 0, 0);
    send_pair(0, 256, -46080, 256, 0);
    send_pair(1, 256, 23040, 256, 23040);
    send_pair(0, 256, 11520, 256, 34560);
    send_pair(0, 256, 92159, 256, -92159);
    send_pair(1, -100, 69120, 100, -23040);
    send_pair(0, 1000, 40000, 1000, -40000);
    send_pair(1, 1000, 10000, 2000, 10000);
    send_pair(0, 24'sh7FFFFF, 11520, 24'sh7FFFFF, 11520);
    send_pair(0, 24'sh7FFFFF, 23040, 24'sh7FFFFF, 23040);
    send_pair(1, 24'sh555555, 18'sh15555, 24'shAAAAAA, 18'sh2AAAA);
    send_pair(0, 24'shAAAAAA, 18'sh2AAAA, 24'sh555555, 18'sh15555);
    s_axis_tvalid <= 0;

    // pause until everything drained
    while (pending != 0) @(negedge clk);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        long_hold = 1;
        repeat (Latency * 3) @(negedge clk);
        long_hold = 0;
      end
      repeat (120) send_pair(1'($urandom_range(0, 1)), rand_radius(), rand_angle(),
                             rand_radius(), rand_angle());
    join
    s_axis_tvalid <= 0;

    for (int n = 0; n < RandomItems - 120; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++)
        send_pair(1'($urandom_range(0, 1)), rand_radius(), rand_angle(),
                  rand_radius(), rand_angle());
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    if (fail_count == 0)
      $display("polar_vector_add_sub_core regression: pass");
    else
      $display("polar_vector_add_sub_core regression: fail");
    $finish;
  end
endmodule
